@@ hw/rtl/sbrd_pkg.sv @@
// shared types, constants and helpers for the byte rotate decryptor
`timescale 1ns / 1ps

package sbrd_pkg;

  localparam int unsigned CTR_W = 64;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  localparam logic [CTR_W-1:0] SEED_VALUE = 64'hB4A57B0F6DEDABED;
  // adding this is the same as subtracting 0x61C8864680B583EB
  localparam logic [CTR_W-1:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
  localparam logic [CTR_W-1:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
  localparam logic [CTR_W-1:0] MIX_MUL_B = 64'h94D049BB133111EB;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       starts_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       string_end;
  } out_item_t;

  // classified item between front and back
  typedef struct packed {
    logic [7:0]       data;
    logic             mix;      // byte needs the keystream rotate
    logic             fin;      // string end flag
    logic [CTR_W-1:0] counter;  // advanced counter, used when mix is set
  } work_t;

  function automatic logic [7:0] rotr8(input logic [7:0] b, input logic [2:0] r);
    logic [15:0] w;
    w = {b, b} >> r;
    return w[7:0];
  endfunction

endpackage

@@ hw/rtl/sbrd_front.sv @@
// front end: header handling, mode and counter update, classification
`timescale 1ns / 1ps

module sbrd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  sbrd_pkg::in_item_t item,
  output sbrd_pkg::work_t   entry
);

  logic [sbrd_pkg::CTR_W-1:0] key_counter;
  logic [sbrd_pkg::CTR_W-1:0] key_counter_next;
  logic                       encrypted_mode;
  logic                       encrypted_mode_next;
  logic [sbrd_pkg::CTR_W-1:0] stepped;

  assign stepped = key_counter + sbrd_pkg::GOLDEN_STEP;

  always_comb begin
    key_counter_next    = key_counter;
    encrypted_mode_next = encrypted_mode;
    entry.data    = item.in_byte;
    entry.mix     = 1'b0;
    entry.fin     = 1'b0;
    entry.counter = stepped;
    if (item.starts_string) begin
      entry.data = 8'd0;
      if (item.in_byte == 8'd0) begin
        entry.fin           = 1'b1;
        encrypted_mode_next = 1'b0;
      end else begin
        encrypted_mode_next = 1'b1;
        key_counter_next    = sbrd_pkg::SEED_VALUE;
      end
    end else if (item.in_byte == 8'd0) begin
      // terminator: counter holds
      entry.fin = 1'b1;
    end else if (encrypted_mode) begin
      entry.mix        = 1'b1;
      key_counter_next = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_counter    <= sbrd_pkg::SEED_VALUE;
      encrypted_mode <= 1'b0;
    end else if (take) begin
      key_counter    <= key_counter_next;
      encrypted_mode <= encrypted_mode_next;
    end
  end

endmodule

@@ hw/rtl/sbrd_queue.sv @@
// short queue between front and back
`timescale 1ns / 1ps

module sbrd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  sbrd_pkg::work_t  wr_data,
  input  logic             rd,
  output sbrd_pkg::work_t  rd_data,
  output logic             full,
  output logic             empty
);

  sbrd_pkg::work_t          slots [sbrd_pkg::QDEPTH];
  logic [sbrd_pkg::QAW-1:0] head;
  logic [sbrd_pkg::QAW-1:0] tail;
  logic [sbrd_pkg::QAW:0]   count;

  assign full    = (count == (sbrd_pkg::QAW+1)'(sbrd_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[head];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[tail] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        tail <= tail + 1'b1;
      end
      if (rd) begin
        head <= head + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/sbrd_back.sv @@
// back end: splitmix finaliser on one shared 32x32 multiplier, rotate, result register
`timescale 1ns / 1ps

module sbrd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  sbrd_pkg::work_t    q_data,
  output logic               q_rd,
  input  logic               pop,
  output logic               empty,
  output sbrd_pkg::out_item_t result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_XOR  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [1:0] STEP_LL = 2'd0;  // low x low, full width
  localparam logic [1:0] STEP_HL = 2'd1;  // high x low, upper half only
  localparam logic [1:0] STEP_LH = 2'd2;  // low x high, upper half only

  logic [1:0]  state;
  logic [1:0]  step;
  logic        pass;
  logic [63:0] op;
  logic [63:0] acc;
  logic [7:0]  data;
  logic        out_valid;
  logic        slot_free;
  logic        res_load;  // result register takes a new value
  logic [63:0] coef;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] fin_mix;

  assign empty     = ~out_valid;
  assign slot_free = ~out_valid | pop;
  assign q_rd      = (state == S_IDLE) && !q_empty && slot_free;
  assign res_load  = (q_rd && !q_data.mix) || ((state == S_OUT) && slot_free);

  assign coef  = pass ? sbrd_pkg::MIX_MUL_B : sbrd_pkg::MIX_MUL_A;
  assign mul_a = (step == STEP_HL) ? op[63:32] : op[31:0];
  assign mul_b = (step == STEP_LH) ? coef[63:32] : coef[31:0];
  assign prod  = mul_a * mul_b;

  assign fin_mix = acc ^ (acc >> 31);

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_rd) begin
          data <= q_data.data;
          op   <= q_data.counter ^ (q_data.counter >> 30);
          step <= STEP_LL;
          pass <= 1'b0;
        end
      end
      S_MUL: begin
        if (step == STEP_LL) begin
          acc <= prod;
        end else begin
          acc[63:32] <= acc[63:32] + prod[31:0];
        end
        step <= step + 1'b1;
      end
      S_XOR: begin
        op   <= acc ^ (acc >> 27);
        step <= STEP_LL;
        pass <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_rd) begin
            if (q_data.mix) begin
              state <= S_MUL;
            end else begin
              result.out_byte   <= q_data.data;
              result.string_end <= q_data.fin;
            end
          end
        end
        S_MUL: begin
          if (step == STEP_LH) begin
            state <= pass ? S_OUT : S_XOR;
          end
        end
        S_XOR: begin
          state <= S_MUL;
        end
        S_OUT: begin
          if (slot_free) begin
            result.out_byte   <= sbrd_pkg::rotr8(data, fin_mix[2:0]);
            result.string_end <= 1'b0;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/splitmix_byte_rotate_decrypt.sv @@
// top level of the byte rotate string decryptor
`timescale 1ns / 1ps

// Byte-serial decryptor for obfuscated strings, queue-like on both sides.
// Each string opens with a header byte (starts_string set): a zero header
// selects plain text and is flagged as a string end, a nonzero header
// selects encrypted text and reloads the 64-bit counter with the seed; the
// header itself comes out as a zero byte. A zero string byte is the
// terminator and comes out as zero with string_end set. In encrypted mode
// every other byte advances the counter by the golden-ratio step and is
// rotated right by the low three bits of the splitmix64 finaliser of the
// new counter. Exactly one result per input, in input order.
// Rate: headers, terminators and plain bytes stream at one per cycle while
// the back end is idle and results are popped. An encrypted byte holds the
// back end: the finaliser's two 64-bit products are each built from three
// passes through one 32x32 multiplier, plus a load, an xor-shift and an
// output step. A four-entry queue after the front end lets input keep
// flowing while the back end is busy; full rises once it fills.

module splitmix_byte_rotate_decrypt (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  sbrd_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output sbrd_pkg::out_item_t result
);

  logic            take;     // input transfer this cycle
  logic            pop_ok;   // result transfer this cycle
  sbrd_pkg::work_t wr_entry;
  sbrd_pkg::work_t rd_entry;
  logic            q_rd;
  logic            q_empty;

  assign take   = push & ~full;
  assign pop_ok = pop & ~empty;

  // front end: mode and counter, one adder per byte
  sbrd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (item),
    .entry (wr_entry)
  );

  // decoupling queue; its full flag is the input side's back-pressure
  sbrd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (take),
    .wr_data (wr_entry),
    .rd      (q_rd),
    .rd_data (rd_entry),
    .full    (full),
    .empty   (q_empty)
  );

  // back end: keystream mixing, rotate and the output register
  sbrd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (rd_entry),
    .q_rd    (q_rd),
    .pop     (pop_ok),
    .empty   (empty),
    .result  (result)
  );

`ifndef SYNTHESIS
  // a header transfer never asks for the rotate
  a_header_no_mix: assert property (@(posedge clk) disable iff (rst)
    take && item.starts_string |-> !wr_entry.mix)
    else $error("header item classified for mixing");

  // a zero byte always ends the string and is never mixed
  a_zero_is_end: assert property (@(posedge clk) disable iff (rst)
    take && (item.in_byte == 8'd0) |-> wr_entry.fin && !wr_entry.mix)
    else $error("zero byte not classified as string end");

  // the back end only reads a queue that holds something
  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_empty)
    else $error("queue read while empty");

  // nothing is waiting on the result side straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result pending after reset");
`endif

endmodule

@@ verif/splitmix_byte_rotate_decrypt_test.sv @@
// self-checking testbench for the splitmix byte rotate string decryptor
`timescale 1ns / 1ps

module splitmix_byte_rotate_decrypt_test;

  localparam int unsigned RANDOM_ITEMS  = 950;
  localparam int unsigned IDLE_PCT      = 11;
  // window of transfers with no idling on either side
  localparam int unsigned BURST_FIRST   = 400;
  localparam int unsigned BURST_LAST    = 600;
  // an encrypted byte holds the back end while it is mixed, the queue has four
  // entries, so the pipe empties well within this
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned QUIET_LIMIT   = 2000;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  sbrd_pkg::in_item_t  item;
  logic                empty;
  logic                pop;
  sbrd_pkg::out_item_t result;

  splitmix_byte_rotate_decrypt dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // whole byte stream, with the hand-written result where a row has one
  sbrd_pkg::in_item_t  byte_stream[$];
  bit                  has_fixed[$];
  sbrd_pkg::out_item_t fixed_out[$];

  // decrypted bytes still owed by the block, oldest first
  sbrd_pkg::out_item_t owed_bytes[$];

  // predictor state: keystream counter and text mode
  logic [sbrd_pkg::CTR_W-1:0] key_ctr;
  logic                       enc_mode;

  int unsigned err_cnt;
  int unsigned sent_cnt;  // driver side
  int unsigned taken_cnt; // input transfers seen by the checker
  int unsigned given_cnt; // output transfers seen by the checker
  int unsigned quiet_cycles;

  always #1 clk = ~clk;

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // splitmix64 finaliser
  function automatic logic [sbrd_pkg::CTR_W-1:0] splitmix_finalise(
    input logic [sbrd_pkg::CTR_W-1:0] z
  );
    logic [sbrd_pkg::CTR_W-1:0] v;
    v = z ^ (z >> 30);
    v = v * sbrd_pkg::MIX_MUL_A;
    v = v ^ (v >> 27);
    v = v * sbrd_pkg::MIX_MUL_B;
    return v ^ (v >> 31);
  endfunction

  // works out one result and moves the predictor state on
  function automatic sbrd_pkg::out_item_t decrypt_byte(input sbrd_pkg::in_item_t it);
    sbrd_pkg::out_item_t        res;
    logic [sbrd_pkg::CTR_W-1:0] mixed;
    logic [2:0]                 amt;
    logic [7:0]                 lo_part;
    logic [7:0]                 hi_part;
    res = '0;
    if (it.starts_string) begin
      // header: zero selects plain text and also ends the string
      if (it.in_byte == 8'h00) begin
        enc_mode       = 1'b0;
        res.string_end = 1'b1;
      end else begin
        enc_mode = 1'b1;
        key_ctr  = sbrd_pkg::SEED_VALUE;
      end
    end else if (it.in_byte == 8'h00) begin
      // terminator, counter stays put
      res.string_end = 1'b1;
    end else if (enc_mode) begin
      key_ctr      = key_ctr + sbrd_pkg::GOLDEN_STEP;
      mixed        = splitmix_finalise(key_ctr);
      amt          = mixed[2:0];
      lo_part      = it.in_byte >> amt;
      hi_part      = it.in_byte << (4'd8 - {1'b0, amt});
      res.out_byte = lo_part | hi_part;
    end else begin
      res.out_byte = it.in_byte;
    end
    return res;
  endfunction

  // one row of the byte stream; fixed rows carry their own result
  function automatic void add_row(input logic [7:0] b, input logic hdr, input bit fixed,
                                  input logic [7:0] want_byte, input logic want_end);
    sbrd_pkg::in_item_t  it;
    sbrd_pkg::out_item_t want;
    it.in_byte       = b;
    it.starts_string = hdr;
    want.out_byte    = want_byte;
    want.string_end  = want_end;
    byte_stream = {byte_stream, it};
    has_fixed   = {has_fixed, fixed};
    fixed_out   = {fixed_out, want};
  endfunction

  // input side: offers the next byte, idling now and then
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) sent_cnt = sent_cnt + 1;
      if (sent_cnt < byte_stream.size() &&
          ((sent_cnt >= BURST_FIRST && sent_cnt < BURST_LAST) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        push <= 1'b1;
        item <= byte_stream[sent_cnt];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // output side: takes results, stalling now and then
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= (given_cnt >= BURST_FIRST && given_cnt < BURST_LAST) ||
             ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // checker: compares each output transfer, predicts on each input transfer
  always @(posedge clk) begin : result_check
    sbrd_pkg::out_item_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (owed_bytes.size() == 0) begin
          report($sformatf("result %0d arrived with nothing owed", given_cnt));
        end else begin
          want = owed_bytes.pop_front();
          if (result.out_byte !== want.out_byte)
            report($sformatf("result %0d: out_byte %h, want %h",
                             given_cnt, result.out_byte, want.out_byte));
          if (result.string_end !== want.string_end)
            report($sformatf("result %0d: string_end %b, want %b",
                             given_cnt, result.string_end, want.string_end));
        end
        given_cnt++;
      end
      if (push && !full) begin
        // the predictor runs on every byte so its state stays in step
        want = decrypt_byte(item);
        if (has_fixed[taken_cnt]) want = fixed_out[taken_cnt];
        owed_bytes = {owed_bytes, want};
        taken_cnt++;
      end
    end
  end

  // watchdog: too long without any transfer means the block has hung
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned len;
    clk          = 1'b0;
    rst          = 1'b1;
    push         = 1'b0;
    pop          = 1'b0;
    item         = '0;
    err_cnt      = 0;
    sent_cnt     = 0;
    taken_cnt    = 0;
    given_cnt    = 0;
    quiet_cycles = 0;
    key_ctr      = sbrd_pkg::SEED_VALUE;
    enc_mode     = 1'b0;

    // directed part: byte, header flag, fixed result or predictor
    // bytes before any header pass through in plain mode
    add_row(8'hFF, 1'b0, 1, 8'hFF, 1'b0);
    add_row(8'h00, 1'b0, 1, 8'h00, 1'b1);  // terminator before any header
    add_row(8'h80, 1'b0, 1, 8'h80, 1'b0);
    add_row(8'h01, 1'b0, 1, 8'h01, 1'b0);
    // zero header: plain text, flagged as string end
    add_row(8'h00, 1'b1, 1, 8'h00, 1'b1);
    add_row(8'hA5, 1'b0, 1, 8'hA5, 1'b0);
    // smallest nonzero header starts an encrypted string
    add_row(8'h01, 1'b1, 1, 8'h00, 1'b0);
    add_row(8'hFF, 1'b0, 1, 8'hFF, 1'b0);  // all ones survives any rotate
    add_row(8'h01, 1'b0, 0, 8'h00, 1'b0);
    add_row(8'h80, 1'b0, 0, 8'h00, 1'b0);
    add_row(8'h7F, 1'b0, 0, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1, 8'h00, 1'b1);  // terminator keeps the counter
    // no new header: counter carries on from the terminator
    add_row(8'h5A, 1'b0, 0, 8'h00, 1'b0);
    // largest header reloads the seed
    add_row(8'hFF, 1'b1, 1, 8'h00, 1'b0);
    add_row(8'hC3, 1'b0, 0, 8'h00, 1'b0);
    add_row(8'hFE, 1'b0, 0, 8'h00, 1'b0);
    // header straight after another one while encrypted
    add_row(8'h80, 1'b1, 1, 8'h00, 1'b0);
    add_row(8'h01, 1'b0, 0, 8'h00, 1'b0);
    // zero header drops back to plain text
    add_row(8'h00, 1'b1, 1, 8'h00, 1'b1);
    add_row(8'h33, 1'b0, 1, 8'h33, 1'b0);
    add_row(8'h00, 1'b0, 1, 8'h00, 1'b1);
    add_row(8'h55, 1'b1, 1, 8'h00, 1'b0);
    add_row(8'hAA, 1'b0, 0, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1, 8'h00, 1'b1);

    // random part: mostly whole strings, the rest loose or broken bytes
    while (byte_stream.size() < RANDOM_ITEMS + 24) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        // header: mostly encrypted strings, some plain ones
        if ($urandom_range(99) < 15) add_row(8'h00, 1'b1, 0, 8'h00, 1'b0);
        else add_row(8'($urandom_range(255, 1)), 1'b1, 0, 8'h00, 1'b0);
        len = $urandom_range(12);
        repeat (len) add_row(8'($urandom_range(255, 1)), 1'b0, 0, 8'h00, 1'b0);
        // now and then the terminator is left off
        if ($urandom_range(9) != 0) add_row(8'h00, 1'b0, 0, 8'h00, 1'b0);
      end else begin
        // noise: any byte, header flag at random, zero bytes made common
        if ($urandom_range(3) == 0) begin
          add_row(8'h00, 1'($urandom_range(1)), 0, 8'h00, 1'b0);
        end else begin
          add_row(8'($urandom_range(255)), 1'($urandom_range(1)), 0, 8'h00, 1'b0);
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // sample away from the rising edge so the counters have settled
    do @(negedge clk);
    while (taken_cnt < byte_stream.size() || owed_bytes.size() != 0);
    // any stray result shows up in the checker during this wait
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sbrd_pkg.sv
hw/rtl/sbrd_front.sv
hw/rtl/sbrd_queue.sv
hw/rtl/sbrd_back.sv
hw/rtl/splitmix_byte_rotate_decrypt.sv
verif/splitmix_byte_rotate_decrypt_test.sv
